// ----- rtl/core/ghash_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_pkg
// Shared types and constants for the GHASH accumulator core.
// ----------------------------------------------------------------------------
package ghash_pkg;

  // Width of one GF(2^128) element.
  localparam int unsigned GF_W = 128;

  // Default number of multiplier bits absorbed per cycle.
  localparam int unsigned GHASH_DIGIT_W = 8;

  // Reduction constant, placed in the top byte of the element.
  localparam logic [7:0] GF_REDUCE_BYTE = 8'hE1;

  // Configuration port index width and register indexes.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SUBKEY_HIGH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SUBKEY_LOW  = CFG_INDEX_W'(1);

  // Input beat: one data block and the start flag.
  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        start_new;
  } block_t;

  // Output beat: the updated running hash.
  typedef struct packed {
    logic [63:0] hash_high;
    logic [63:0] hash_low;
  } hash_t;

endpackage

// ----- rtl/core/ghash_accumulator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator_core
// GHASH block absorber: X = (X ^ block) * H in GF(2^128).
// ----------------------------------------------------------------------------
// Usage:
// The hash subkey H is written through the wr_en / wr_index / wr_data port,
// index 0 for the upper half and index 1 for the lower half, while the core
// is idle. Data blocks arrive as beats on the blk channel (valid/ready); a
// set start_new flag clears the running hash before the block is absorbed.
// Each block yields one beat on the hash channel carrying the updated hash.
// The operands load into the multiplier at the accepting edge, which then
// absorbs DIGIT_W bits of the operand per cycle until all 128 bits are in;
// the product is then captured, and only after that capture does the core
// accept the next block, so blocks never overlap in the multiplier.
// The result sits in an output register; blk_ready returns as soon as the
// result is registered, even if the receiver has not taken it yet. If the
// receiver still stalls the previous result when a product finishes, the
// product waits in the accumulator until the output register frees.
// Reset clears the subkey, the running hash and all handshake state.
// ----------------------------------------------------------------------------
module ghash_accumulator_core
  import ghash_pkg::*;
#(
  parameter int unsigned DIGIT_W = GHASH_DIGIT_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   blk_valid,
  output logic                   blk_ready,
  input  block_t                 blk,
  output logic                   hash_valid,
  input  logic                   hash_ready,
  output hash_t                  hash,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [63:0]            wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t          state;
  logic [63:0]     subkey_high;
  logic [63:0]     subkey_low;
  logic [GF_W-1:0] acc;
  logic [GF_W-1:0] mul_x;
  logic [GF_W-1:0] mul_prod;
  logic            mul_busy;
  logic            mul_done;
  logic            blk_beat;
  logic            hash_load;

  assign blk_ready = (state == S_IDLE);
  assign blk_beat  = blk_valid && blk_ready;

  // Absorb the block into the running hash, or into zero on a new hash.
  assign mul_x = {blk.block_high, blk.block_low} ^ (blk.start_new ? '0 : acc);

  // A finished product goes out at once unless the output register still
  // holds a stalled beat; a held product goes out when that beat leaves.
  assign hash_load = ((state == S_RUN) && mul_done && !mul_busy &&
                      (!hash_valid || hash_ready)) ||
                     ((state == S_HOLD) && hash_ready);

  // Subkey registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      subkey_high <= '0;
      subkey_low  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SUBKEY_HIGH: subkey_high <= wr_data;
        REG_SUBKEY_LOW:  subkey_low  <= wr_data;
        default: ;
      endcase
    end
  end

  ghash_gfmul #(
    .DIGIT_W(DIGIT_W)
  ) u_gfmul (
    .clk    (clk),
    .rst    (rst),
    .start  (blk_beat),
    .x_in   (mul_x),
    .h_in   ({subkey_high, subkey_low}),
    .busy   (mul_busy),
    .done   (mul_done),
    .product(mul_prod)
  );

  // Control, running hash and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hash_valid <= 1'b0;
      acc        <= '0;
    end else begin
      if (hash_load) begin
        hash       <= (state == S_HOLD) ? acc : mul_prod;
        hash_valid <= 1'b1;
      end else if (hash_valid && hash_ready) begin
        hash_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (blk_beat) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (mul_done && !mul_busy) begin
            acc <= mul_prod;
            if (hash_load) begin
              state <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (hash_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/ghash_gfmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_gfmul
// Digit-serial GF(2^128) multiplier in the bit-reflected GCM convention.
// ----------------------------------------------------------------------------
module ghash_gfmul
  import ghash_pkg::*;
#(
  parameter int unsigned DIGIT_W = GHASH_DIGIT_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [GF_W-1:0] x_in,
  input  logic [GF_W-1:0] h_in,
  output logic            busy,
  output logic            done,
  output logic [GF_W-1:0] product
);

  localparam int unsigned STEPS = GF_W / DIGIT_W;
  localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [GF_W-1:0]  x;
  logic [GF_W-1:0]  v;
  logic [GF_W-1:0]  z;
  logic [CNT_W-1:0] cnt;
  logic [GF_W-1:0]  v_next;
  logic [GF_W-1:0]  z_next;

  // One digit of shift-and-xor: bit 127 of x is the coefficient of x^0.
  always_comb begin
    logic [GF_W-1:0] vt;
    logic [GF_W-1:0] zt;
    logic            carry;
    vt = v;
    zt = z;
    for (int i = 0; i < DIGIT_W; i++) begin
      if (x[GF_W-1-i]) begin
        zt = zt ^ vt;
      end
      carry = vt[0];
      vt = vt >> 1;
      if (carry) begin
        vt[GF_W-1 -: 8] = vt[GF_W-1 -: 8] ^ GF_REDUCE_BYTE;
      end
    end
    v_next = vt;
    z_next = zt;
  end

  // Sequencer: load operands, then run one digit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        x    <= x_in;
        v    <= h_in;
        z    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x   <= x << DIGIT_W;
        v   <= v_next;
        z   <= z_next;
        cnt <= cnt + CNT_W'(1);
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = z;

endmodule

// ----- rtl/core/ghash_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_checker
// Port-level checks for the GHASH accumulator core, bound into ghash_accumulator_core.
// ----------------------------------------------------------------------------
module ghash_checker
  import ghash_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   blk_valid,
  input logic   blk_ready,
  input logic   hash_valid,
  input logic   hash_ready,
  input hash_t  hash
);

  // A stalled result beat stays valid and unchanged.
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    hash_valid && !hash_ready |=> hash_valid && $stable(hash))
    else $error("stalled hash beat changed or dropped");

  // Accepting a block occupies the multiplier, so no second block follows.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready |=> !blk_ready)
    else $error("block accepted while multiplier busy");

  // No result can be on the channel right after reset.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !hash_valid)
    else $error("hash beat valid after reset");

  // A result never appears in the cycle after a block is accepted.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready && !hash_valid |=> !hash_valid)
    else $error("hash beat appeared before the multiply could finish");

endmodule

bind ghash_accumulator_core ghash_checker u_ghash_checker (
  .clk       (clk),
  .rst       (rst),
  .blk_valid (blk_valid),
  .blk_ready (blk_ready),
  .hash_valid(hash_valid),
  .hash_ready(hash_ready),
  .hash      (hash)
);

// ----- tb/ghash_accumulator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator_checker
// Watches the subkey write port and both beat channels of the GHASH core.
// It keeps its own copy of the subkey and the running hash. For every
// accepted block it computes the updated hash in GF(2^128) and queues it.
// Each hash beat is compared, half by half, against the oldest queued hash.
// ----------------------------------------------------------------------------
module ghash_accumulator_checker
  import ghash_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   blk_valid,
  input  logic                   blk_ready,
  input  block_t                 blk,
  input  logic                   hash_valid,
  input  logic                   hash_ready,
  input  hash_t                  hash,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [63:0]            wr_data,
  output int unsigned            pending,
  output int unsigned            errors
);

  logic [GF_W-1:0] subkey;
  logic [GF_W-1:0] running_hash;
  logic [GF_W-1:0] expected_hashes[$];

  // Bit-reflected GCM multiply: bit 127 is the coefficient of x^0, so the
  // operand is scanned from its top bit and V shifts toward the low end.
  function automatic logic [GF_W-1:0] gf128_mul_reflected(input logic [GF_W-1:0] x,
                                                          input logic [GF_W-1:0] h);
    logic [GF_W-1:0] prod;
    logic [GF_W-1:0] v;
    prod = '0;
    v = h;
    for (int i = GF_W - 1; i >= 0; i--) begin
      if (x[i]) begin
        prod ^= v;
      end
      if (v[0]) begin
        v = (v >> 1) ^ {GF_REDUCE_BYTE, {(GF_W-8){1'b0}}};
      end else begin
        v = v >> 1;
      end
    end
    return prod;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    $display("%0t ns: ERROR: %s", $time, msg);
  endtask

  // Sample all channels at the rising edge. Hash beats are checked before a
  // block beat of the same edge is queued, so a stray beat never matches it.
  always @(posedge clk) begin : monitor
    logic [GF_W-1:0] want;
    logic [GF_W-1:0] absorbed;
    if (rst) begin
      subkey = '0;
      running_hash = '0;
      expected_hashes.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SUBKEY_HIGH: subkey[127:64] = wr_data;
          REG_SUBKEY_LOW:  subkey[63:0]   = wr_data;
          default: ;
        endcase
      end

      if (hash_valid && hash_ready) begin
        if (expected_hashes.size() == 0) begin
          report_error($sformatf("hash beat %h_%h with no block outstanding",
                                 hash.hash_high, hash.hash_low));
        end else begin
          want = expected_hashes.pop_front();
          if (hash.hash_high !== want[127:64]) begin
            report_error($sformatf("hash_high got %h, expected %h",
                                   hash.hash_high, want[127:64]));
          end
          if (hash.hash_low !== want[63:0]) begin
            report_error($sformatf("hash_low got %h, expected %h",
                                   hash.hash_low, want[63:0]));
          end
        end
      end

      if (blk_valid && blk_ready) begin
        if (blk.start_new) begin
          running_hash = '0;
        end
        absorbed = running_hash ^ {blk.block_high, blk.block_low};
        running_hash = gf128_mul_reflected(absorbed, subkey);
        expected_hashes.push_back(running_hash);
      end
    end
    pending <= expected_hashes.size();
  end

endmodule

// ----- tb/ghash_accumulator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_accumulator_core_tb
// Drives the GHASH core with directed and random blocks under random stalls
// on both channels, reprograms the subkey between idle phases, and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module ghash_accumulator_core_tb;
  import ghash_pkg::*;

  localparam int unsigned RANDOM_BLOCKS = 1330;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   blk_valid = 1'b0;
  logic                   blk_ready;
  block_t                 blk = '0;
  logic                   hash_valid;
  logic                   hash_ready = 1'b0;
  hash_t                  hash;
  logic                   wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index = REG_SUBKEY_HIGH;
  logic [63:0]            wr_data = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned stall_cycles = 0;
  bit          back_to_back = 1'b0;

  ghash_accumulator_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .blk_valid  (blk_valid),
    .blk_ready  (blk_ready),
    .blk        (blk),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash       (hash),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  ghash_accumulator_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .blk_valid  (blk_valid),
    .blk_ready  (blk_ready),
    .blk        (blk),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash       (hash),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next beat on either side; none in burst stretches.
  function automatic int unsigned draw_gap();
    return back_to_back ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [127:0] rand_subkey();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 128'h1 << $urandom_range(0, 127);
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  // Offer one block beat and return at the edge that accepts it. Valid is
  // left high so a back-to-back beat needs only one assignment.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input bit start);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      blk_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    blk_valid <= 1'b1;
    blk <= '{block_high: hi, block_low: lo, start_new: start};
    do @(posedge clk); while (!blk_ready);
  endtask

  // Wait until every hash beat has been delivered and the core is quiet.
  task automatic wait_idle();
    blk_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_subkey(input logic [127:0] h, input bit wr_high, input bit wr_low);
    if (wr_high) begin
      wr_en <= 1'b1;
      wr_index <= REG_SUBKEY_HIGH;
      wr_data <= h[127:64];
      @(posedge clk);
    end
    if (wr_low) begin
      wr_en <= 1'b1;
      wr_index <= REG_SUBKEY_LOW;
      wr_data <= h[63:0];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // Hash receiver: random stall before each beat.
  initial begin : hash_sink
    int unsigned gap;
    @(negedge rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        hash_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hash_ready <= 1'b1;
      do @(posedge clk); while (!hash_valid);
    end
  end

  // Abort when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (blk_valid && blk_ready) || (hash_valid && hash_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [127:0] key;
    int unsigned  sent;
    int unsigned  phase_len;
    int unsigned  halves;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Subkey still zero from reset; the first block continues the zero hash.
    send_block(rand_word(), rand_word(), 1'b0);
    send_block(rand_word(), rand_word(), 1'b1);

    // Subkey equal to one: the product is the absorbed block itself.
    wait_idle();
    load_subkey({1'b1, 127'b0}, 1'b1, 1'b1);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block(rand_word(), rand_word(), 1'b0);

    // All-ones subkey with one-sided and all-ones blocks.
    wait_idle();
    load_subkey('1, 1'b1, 1'b1);
    send_block('1, '0, 1'b1);
    send_block('0, '1, 1'b0);
    send_block('1, '1, 1'b0);

    // Subkey x^127: its first shift already folds the reduction constant in.
    wait_idle();
    load_subkey(128'h1, 1'b1, 1'b1);
    send_block(64'h8000_0000_0000_0000, '0, 1'b1);
    send_block('0, 64'h1, 1'b0);
    send_block(rand_word(), rand_word(), 1'b0);

    // Subkey changed halfway through a hash, one half at a time.
    wait_idle();
    load_subkey({$urandom, $urandom, $urandom, $urandom}, 1'b1, 1'b1);
    send_block(rand_word(), rand_word(), 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);
    wait_idle();
    load_subkey({$urandom, $urandom, $urandom, $urandom}, 1'b0, 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);
    wait_idle();
    load_subkey({$urandom, $urandom, $urandom, $urandom}, 1'b1, 1'b0);
    send_block(rand_word(), rand_word(), 1'b0);

    // Zero subkey clears the hash, then a fresh key continues from zero.
    wait_idle();
    load_subkey('0, 1'b1, 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);
    wait_idle();
    load_subkey({$urandom, $urandom, $urandom, $urandom}, 1'b1, 1'b1);
    send_block(rand_word(), rand_word(), 1'b0);

    // Random phases: a new subkey, then message runs with occasional restarts.
    sent = 0;
    while (sent < RANDOM_BLOCKS) begin
      phase_len = $urandom_range(20, 120);
      wait_idle();
      key = rand_subkey();
      halves = $urandom_range(0, 5);
      load_subkey(key, halves != 1, halves != 0);
      back_to_back = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        send_block(rand_word(), rand_word(), $urandom_range(0, 7) == 0);
      end
      sent += phase_len;
    end

    back_to_back = 1'b0;
    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
